// ----- hw/rtl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg - shared types and constants of the change dispenser
// Field widths of the item ports, report kind codes and the divider status.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // fixed port field widths
  localparam int IDX_W   = 4;
  localparam int FIELD_W = 16;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 5;

  // input item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // result report kinds
  localparam logic [KIND_W-1:0] REP_STOCK = 2'd0;
  localparam logic [KIND_W-1:0] REP_PAID  = 2'd1;
  localparam logic [KIND_W-1:0] REP_DONE  = 2'd2;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } gcd_div_stat_t;

endpackage

// ----- hw/rtl/gcd_ram.sv -----
// ----------------------------------------------------------------------------
// gcd_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/gcd_div.sv -----
// ----------------------------------------------------------------------------
// gcd_div - radix-2 restoring divider
// After start, done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module gcd_div
  import gcd_pkg::*;
#(
  parameter int W = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output gcd_div_stat_t stat,
  output logic [W-1:0]  quotient
);

  localparam int CNW = $clog2(W + 1);

  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [W-1:0]   dsr_r, dsr_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     rem_sh;
  logic [W:0]     diff;
  logic           ge;

  // one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
      cnt_nxt = CNW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ----- hw/rtl/greedy_change_dispenser.sv -----
// ----------------------------------------------------------------------------
// greedy_change_dispenser - greedy change making with limited stock
// Slot table {value, stock} in a RAM; each request walks the active slots,
// pays min(stock, remaining / value) per slot and reports stock, payments
// and the undispensed remainder.
//
//   channel  ports                                     handshake
//   -------  ----------------------------------------  ----------------------
//   input    in_kind in_slot_index in_denom_value       start & !busy
//            in_stock_count in_request_amount
//   result   out_report_kind out_face_value             out_strobe, 1 cycle
//            out_piece_count out_leftover out_last
//   config   cfg_wdata (slot_count)                     cfg_we
//
// A load beat is written to the slot RAM at its accepting edge; busy stays low.
// A request walks each active slot through a RAM read, the bit-serial divide
// over VW = min(VALUE_BITS, 16) bits, a multiply and the write-back, then a
// second pass over the paid RAM. Results leave one per cycle at most and
// cannot be held off. Reset clears only control state and slot_count; slot
// RAM contents are undefined until loaded.
// ----------------------------------------------------------------------------
module greedy_change_dispenser
  import gcd_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [IDX_W-1:0]   in_slot_index,
  input  logic [FIELD_W-1:0] in_denom_value,
  input  logic [FIELD_W-1:0] in_stock_count,
  input  logic [FIELD_W-1:0] in_request_amount,
  // result channel
  output logic               out_strobe,
  output logic [KIND_W-1:0]  out_report_kind,
  output logic [FIELD_W-1:0] out_face_value,
  output logic [FIELD_W-1:0] out_piece_count,
  output logic [FIELD_W-1:0] out_leftover,
  output logic               out_last,
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  // value width as kept: port fields are 16 bits
  localparam int VW  = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int EW  = VW + FIELD_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_LAT   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_P2RD  = 4'd6;
  localparam logic [3:0] S_P2OUT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   slot_count_r, slot_count_nxt;
  logic [CW-1:0]      active_r, active_nxt;
  logic [CW-1:0]      slot_r, slot_nxt;
  logic [VW-1:0]      rem_r, rem_nxt;
  logic [VW-1:0]      val_r, val_nxt;
  logic [FIELD_W-1:0] stk_r, stk_nxt;
  logic [FIELD_W-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0]      prod_r, prod_nxt;

  logic               ostb_r, ostb_nxt;
  logic [KIND_W-1:0]  okind_r, okind_nxt;
  logic [FIELD_W-1:0] oface_r, oface_nxt;
  logic [FIELD_W-1:0] opiece_r, opiece_nxt;
  logic [FIELD_W-1:0] oleft_r, oleft_nxt;
  logic               olast_r, olast_nxt;

  // slot RAM ports
  logic               tab_we;
  logic [AW-1:0]      tab_waddr;
  logic [EW-1:0]      tab_wdata;
  logic [EW-1:0]      tab_rdata;
  // paid RAM ports
  logic               paid_we;
  logic [EW-1:0]      paid_rdata;
  // divider
  logic               div_start;
  gcd_div_stat_t      div_stat;
  logic [VW-1:0]      div_quo;

  logic               accept;
  logic               load_wr;
  logic [FIELD_W-1:0] quo_ext;
  logic [FIELD_W-1:0] stk_left;
  logic               last_slot;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign load_wr   = accept && (in_kind == KIND_LOAD) && (32'(in_slot_index) < SLOTS);
  assign quo_ext   = FIELD_W'(div_quo);
  assign stk_left  = stk_r - cnt_r;
  assign last_slot = ((slot_r + 1'b1) == active_r);

  // slot table: load beats and dispense write-back share the write port
  assign tab_we    = load_wr || (state_r == S_WB);
  assign tab_waddr = (state_r == S_WB) ? slot_r[AW-1:0] : AW'(in_slot_index);
  assign tab_wdata = (state_r == S_WB) ? {val_r, stk_left}
                                       : {in_denom_value[VW-1:0], in_stock_count};
  assign paid_we   = (state_r == S_WB);
  assign div_start = (state_r == S_LAT);

  gcd_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (slot_r[AW-1:0]),
    .rdata (tab_rdata)
  );

  gcd_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_paid_ram (
    .clk   (clk),
    .we    (paid_we),
    .waddr (slot_r[AW-1:0]),
    .wdata ({val_r, cnt_r}),
    .raddr (slot_r[AW-1:0]),
    .rdata (paid_rdata)
  );

  gcd_div #(.W(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (tab_rdata[EW-1:FIELD_W]),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = cfg_we ? cfg_wdata : slot_count_r;
    active_nxt     = active_r;
    slot_nxt       = slot_r;
    rem_nxt        = rem_r;
    val_nxt        = val_r;
    stk_nxt        = stk_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    ostb_nxt       = 1'b0;
    okind_nxt      = okind_r;
    oface_nxt      = oface_r;
    opiece_nxt     = opiece_r;
    oleft_nxt      = oleft_r;
    olast_nxt      = olast_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_REQUEST)) begin
          active_nxt = (32'(slot_count_r) > SLOTS) ? CW'(SLOTS) : CW'(slot_count_r);
          slot_nxt   = '0;
          rem_nxt    = in_request_amount[VW-1:0];
          state_nxt  = (active_nxt == '0) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LAT;
      end
      S_LAT: begin
        val_nxt   = tab_rdata[EW-1:FIELD_W];
        stk_nxt   = tab_rdata[FIELD_W-1:0];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (val_r == '0) begin
            cnt_nxt = '0;
          end else begin
            cnt_nxt = (quo_ext < stk_r) ? quo_ext : stk_r;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = EW'(cnt_r) * EW'(val_r);
        state_nxt = S_WB;
      end
      S_WB: begin
        // payment never exceeds the remaining amount
        rem_nxt    = rem_r - prod_r[VW-1:0];
        ostb_nxt   = 1'b1;
        okind_nxt  = REP_STOCK;
        oface_nxt  = FIELD_W'(val_r);
        opiece_nxt = stk_left;
        oleft_nxt  = '0;
        olast_nxt  = 1'b0;
        if (last_slot) begin
          slot_nxt  = '0;
          state_nxt = S_P2RD;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_P2RD: begin
        state_nxt = S_P2OUT;
      end
      S_P2OUT: begin
        if (paid_rdata[FIELD_W-1:0] != '0) begin
          ostb_nxt   = 1'b1;
          okind_nxt  = REP_PAID;
          oface_nxt  = FIELD_W'(paid_rdata[EW-1:FIELD_W]);
          opiece_nxt = paid_rdata[FIELD_W-1:0];
          oleft_nxt  = '0;
          olast_nxt  = 1'b0;
        end
        if (last_slot) begin
          state_nxt = S_DONE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_P2RD;
        end
      end
      S_DONE: begin
        ostb_nxt   = 1'b1;
        okind_nxt  = REP_DONE;
        oface_nxt  = '0;
        opiece_nxt = '0;
        oleft_nxt  = FIELD_W'(rem_r);
        olast_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= '0;
      ostb_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      ostb_r       <= ostb_nxt;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    active_r <= active_nxt;
    slot_r   <= slot_nxt;
    rem_r    <= rem_nxt;
    val_r    <= val_nxt;
    stk_r    <= stk_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    okind_r  <= okind_nxt;
    oface_r  <= oface_nxt;
    opiece_r <= opiece_nxt;
    oleft_r  <= oleft_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_strobe      = ostb_r;
  assign out_report_kind = okind_r;
  assign out_face_value  = oface_r;
  assign out_piece_count = opiece_r;
  assign out_leftover    = oleft_r;
  assign out_last        = olast_r;

endmodule
